// ===== rtl/core/atn_pkg.sv =====
// ----------------------------------------------------------------------------
// atn_pkg
// shared widths, octant codes, stage payload types and the arctangent rom
// ----------------------------------------------------------------------------
package atn_pkg;

  localparam int IN_W            = 16;
  localparam int ANGLE_W         = 16;
  localparam int LUT_ENTRIES     = 256;
  localparam int ANGLE_FRAC_BITS = 13;

  localparam int MAG_W = IN_W + 1;
  localparam int IDX_W = $clog2(LUT_ENTRIES);
  localparam int NUM_W = MAG_W + IDX_W;

  localparam real PI_R = 3.14159265358979323846;
  localparam int  PI_Q      = $rtoi(PI_R * (2.0 ** ANGLE_FRAC_BITS) + 0.5);
  localparam int  HALF_PI_Q = $rtoi(PI_R / 2.0 * (2.0 ** ANGLE_FRAC_BITS) + 0.5);

  // ratio step between neighboring table entries
  localparam real LUT_STEP_R = 1.0 / real'(LUT_ENTRIES - 1);

  // octant code: {x negative, y negative, |x| <= |y|}
  typedef enum logic [2:0] {
    OCT_XP_YP_LO = 3'd0,
    OCT_XP_YP_HI = 3'd1,
    OCT_XP_YN_LO = 3'd2,
    OCT_XP_YN_HI = 3'd3,
    OCT_XN_YP_LO = 3'd4,
    OCT_XN_YP_HI = 3'd5,
    OCT_XN_YN_LO = 3'd6,
    OCT_XN_YN_HI = 3'd7
  } oct_t;

  typedef struct packed {
    oct_t             code;
    logic             zero;
    logic [MAG_W-1:0] mn;
    logic [MAG_W-1:0] mx;
  } mag_item_t;

  typedef struct packed {
    oct_t             code;
    logic             zero;
    logic [NUM_W-1:0] rem;
    logic [MAG_W-1:0] mx;
    logic [IDX_W-1:0] quo;
  } div_item_t;

  typedef struct packed {
    oct_t             code;
    logic             zero;
    logic [IDX_W-1:0] quo;
  } idx_item_t;

  typedef logic [ANGLE_W-1:0] lut_arr_t [LUT_ENTRIES];

  // entry i = round(atan(i / (entries - 1)) * 2^frac), built at elaboration
  function automatic lut_arr_t build_lut();
    lut_arr_t tab;
    real      r;
    for (int i = 0; i < LUT_ENTRIES; i++) begin
      r = $atan(real'(i) * LUT_STEP_R) * (2.0 ** ANGLE_FRAC_BITS);
      tab[i] = ANGLE_W'($rtoi(r + 0.5));
    end
    return tab;
  endfunction

  localparam lut_arr_t LUT_ROM = build_lut();

endpackage

// ===== rtl/core/atan2_octant_lut.sv =====
// ----------------------------------------------------------------------------
// atan2_octant_lut
// four-quadrant arctangent: octant fold, pipelined ratio divide, table lookup
// ----------------------------------------------------------------------------
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   x_val, y_val   (signed 16 bit each)
//   output   out_valid  out_stall  angle          (signed Q2.13, pi = 25736)
//
// one item per cycle sustained while out_stall stays low; 2 prep stages,
// 8 divider stages (one quotient bit each) and 2 for rom read and fold
// synchronous active-high reset clears every stage valid bit; data regs keep
// each stage holds while its successor is full and stalled; bubbles collapse,
// and the input is taken while a finished angle waits at the output if a stage is empty
//
module atan2_octant_lut (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [atn_pkg::IN_W-1:0]     x_val,
  input  logic signed [atn_pkg::IN_W-1:0]     y_val,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [atn_pkg::ANGLE_W-1:0]  angle
);
  import atn_pkg::*;

  // prep -> divider transfer
  logic      prep_valid;
  logic      prep_stall;
  div_item_t prep_item;

  // divider -> fold transfer
  logic      div_valid;
  logic      div_stall;
  idx_item_t div_item;

  // magnitudes, octant code and dividend min * (entries - 1)
  atn_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_val     (x_val),
    .y_val     (y_val),
    .out_valid (prep_valid),
    .out_stall (prep_stall),
    .out_item  (prep_item)
  );

  // table index = floor(dividend / max), always below the table size
  atn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_stall  (prep_stall),
    .in_item   (prep_item),
    .out_valid (div_valid),
    .out_stall (div_stall),
    .out_item  (div_item)
  );

  // rom read and fold; both components zero forces a zero angle
  atn_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_stall  (div_stall),
    .in_item   (div_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
  );

endmodule

// ===== rtl/core/atn_prep.sv =====
// ----------------------------------------------------------------------------
// atn_prep
// magnitudes, octant code, min/max ordering and the scaled dividend
// ----------------------------------------------------------------------------
module atn_prep (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [atn_pkg::IN_W-1:0]     x_val,
  input  logic signed [atn_pkg::IN_W-1:0]     y_val,
  output logic                                out_valid,
  input  logic                                out_stall,
  output atn_pkg::div_item_t                  out_item
);
  import atn_pkg::*;

  logic signed [MAG_W-1:0] sx, sy;
  logic [MAG_W-1:0]        ax, ay;
  logic                    x_le_y;
  mag_item_t               mag_next;
  mag_item_t               mag;
  logic                    mag_valid;
  logic                    mag_ready;
  logic                    out_ready;
  div_item_t               div_next;

  // stage 1: magnitudes and octant
  always_comb begin
    sx = MAG_W'(x_val);
    sy = MAG_W'(y_val);
    ax = sx[MAG_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
    ay = sy[MAG_W-1] ? MAG_W'(-sy) : MAG_W'(sy);
    x_le_y = (ax <= ay);
    mag_next.code = oct_t'({x_val[IN_W-1], y_val[IN_W-1], x_le_y});
    mag_next.zero = (ax == '0) && (ay == '0);
    mag_next.mn   = x_le_y ? ax : ay;
    mag_next.mx   = x_le_y ? ay : ax;
  end

  assign out_ready = !out_valid || !out_stall;
  assign mag_ready = !mag_valid || out_ready;
  assign in_stall  = !mag_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (mag_ready) begin
      mag_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_ready && in_valid) begin
      mag <= mag_next;
    end
  end

  // stage 2: dividend = min * (entries - 1)
  always_comb begin
    div_next.code = mag.code;
    div_next.zero = mag.zero;
    div_next.rem  = NUM_W'(NUM_W'(mag.mn) * NUM_W'(LUT_ENTRIES - 1));
    div_next.mx   = mag.mx;
    div_next.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mag_valid) begin
      out_item <= div_next;
    end
  end

endmodule

// ===== rtl/core/atn_div.sv =====
// ----------------------------------------------------------------------------
// atn_div
// pipelined restoring divider, one quotient bit per stage, msb first
// ----------------------------------------------------------------------------
module atn_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  atn_pkg::div_item_t     in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output atn_pkg::idx_item_t     out_item
);
  import atn_pkg::*;

  div_item_t stg [IDX_W];
  div_item_t stg_next [IDX_W];
  logic      vld [IDX_W];
  logic      rdy [IDX_W];

  for (genvar k = 0; k < IDX_W; k++) begin : g_stage
    localparam int BIT = IDX_W - 1 - k;

    div_item_t        src;
    logic             src_valid;
    logic [NUM_W-1:0] dvs;

    if (k == 0) begin : g_first
      assign src       = in_item;
      assign src_valid = in_valid;
    end else begin : g_rest
      assign src       = stg[k-1];
      assign src_valid = vld[k-1];
    end

    if (k == IDX_W - 1) begin : g_last
      assign rdy[k] = !vld[k] || !out_stall;
    end else begin : g_mid
      assign rdy[k] = !vld[k] || rdy[k+1];
    end

    // quotient is known to fit in IDX_W bits since min <= max
    always_comb begin
      dvs = NUM_W'(src.mx) << BIT;
      stg_next[k] = src;
      if (src.rem >= dvs) begin
        stg_next[k].rem      = src.rem - dvs;
        stg_next[k].quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_valid) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign in_stall       = !rdy[0];
  assign out_valid      = vld[IDX_W-1];
  assign out_item.code  = stg[IDX_W-1].code;
  assign out_item.zero  = stg[IDX_W-1].zero;
  assign out_item.quo   = stg[IDX_W-1].quo;

endmodule

// ===== rtl/core/atn_fold.sv =====
// ----------------------------------------------------------------------------
// atn_fold
// rom lookup, then octant folding into the final angle
// ----------------------------------------------------------------------------
module atn_fold (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  atn_pkg::idx_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [atn_pkg::ANGLE_W-1:0]   angle
);
  import atn_pkg::*;

  localparam logic signed [ANGLE_W:0] PI_S      = (ANGLE_W + 1)'(PI_Q);
  localparam logic signed [ANGLE_W:0] HALF_PI_S = (ANGLE_W + 1)'(HALF_PI_Q);

  logic                    lut_valid;
  logic                    lut_ready;
  logic                    out_ready;
  logic [ANGLE_W-1:0]      lut_val;
  oct_t                    lut_code;
  logic                    lut_zero;
  logic signed [ANGLE_W:0] t_s;
  logic signed [ANGLE_W:0] ang_wide;

  assign out_ready = !out_valid || !out_stall;
  assign lut_ready = !lut_valid || out_ready;
  assign in_stall  = !lut_ready;

  // stage 1: table read
  always_ff @(posedge clk) begin
    if (rst) begin
      lut_valid <= 1'b0;
    end else if (lut_ready) begin
      lut_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lut_ready && in_valid) begin
      lut_val  <= LUT_ROM[in_item.quo];
      lut_code <= in_item.code;
      lut_zero <= in_item.zero;
    end
  end

  // stage 2: fold by octant
  always_comb begin
    t_s = $signed({1'b0, lut_val});
    case (lut_code)
      OCT_XP_YP_LO: ang_wide = t_s;
      OCT_XP_YP_HI: ang_wide = HALF_PI_S - t_s;
      OCT_XP_YN_LO: ang_wide = -t_s;
      OCT_XP_YN_HI: ang_wide = t_s - HALF_PI_S;
      OCT_XN_YP_LO: ang_wide = PI_S - t_s;
      OCT_XN_YP_HI: ang_wide = HALF_PI_S + t_s;
      OCT_XN_YN_LO: ang_wide = t_s - PI_S;
      OCT_XN_YN_HI: ang_wide = -HALF_PI_S - t_s;
      default:      ang_wide = '0;
    endcase
    if (lut_zero) begin
      ang_wide = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= lut_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && lut_valid) begin
      angle <= ang_wide[ANGLE_W-1:0];
    end
  end

endmodule

// ===== rtl/core/atn_check.sv =====
// ----------------------------------------------------------------------------
// atn_check
// port-level checks on the arctangent block, bound to the top level
// ----------------------------------------------------------------------------
module atn_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [atn_pkg::IN_W-1:0]     x_val,
  input logic signed [atn_pkg::IN_W-1:0]     y_val,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [atn_pkg::ANGLE_W-1:0]  angle
);
  import atn_pkg::*;

  localparam logic signed [ANGLE_W-1:0] PI_A = ANGLE_W'(PI_Q);

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle))
    else $error("stalled angle changed");

  // every angle lies in -pi..pi
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle >= -PI_A) && (angle <= PI_A))
    else $error("angle out of range");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // with the output free the whole pipe can advance
  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    !out_valid || !out_stall |-> !in_stall)
    else $error("input stalled while output free");

endmodule

bind atan2_octant_lut atn_check u_atn_check (.*);

// ===== tb/atan2_octant_lut_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atan2_octant_lut_tb
// self-checking bench for the octant-folded table arctangent
// ----------------------------------------------------------------------------
//
// A driver pulls (x, y) vector pairs from a pending queue and presents them on
// the input channel. At every accepted transfer the expected angle is worked
// out by a local model: its own arctangent table built with integer series
// arithmetic, plus the octant fold. The expected angle is queued, and the
// monitor checks each output transfer against the oldest entry. A directed
// set of corner vectors comes first. Random vectors follow in four phases:
// no idling, sender gaps, receiver stalls, and both.
//
module atan2_octant_lut_tb;
  import atn_pkg::*;

  // series is carried with 40 fraction bits, then rounded half up
  localparam int WORK_FRAC       = 40;
  localparam int DROP_BITS       = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int RAND_PER_PHASE  = 160;
  localparam int DRAIN_CYCLES    = 16;  // pipeline is 12 deep
  localparam int LAST_PHASE      = 3;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
  } vec_pair_t;

  typedef struct {
    vec_pair_t                 src;
    logic signed [ANGLE_W-1:0] angle;
  } angle_due_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [IN_W-1:0]     x_val = '0;
  logic signed [IN_W-1:0]     y_val = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [ANGLE_W-1:0]  angle;

  vec_pair_t   pair_q [$];        // vectors waiting to be driven
  angle_due_t  angle_due_q [$];   // angles owed by the block, oldest first

  int          atan_tab [LUT_ENTRIES];
  int          pi_fx;
  int          half_pi_fx;

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          pairs_sent    = 0;
  int          angles_seen   = 0;
  int          errors        = 0;

  always #5 clk = ~clk;

  atan2_octant_lut u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_val     (x_val),
    .y_val     (y_val),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
  );

  // atan(i/m) by euler's series in unsigned integer arithmetic,
  // every intermediate stays below 2^57 for m = 255
  function automatic longint unsigned atan_series(longint unsigned i,
                                                  longint unsigned m);
    longint unsigned den;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned n;
    den = m * m + i * i;
    if (den == 0) return 0;
    term = ((i * m) << WORK_FRAC) / den;
    sum  = term;
    n    = 1;
    while (n < 200 && term != 0) begin
      term = (term * (i * i)) / den;
      term = (term * (2 * n)) / (2 * n + 1);
      sum  = sum + term;
      n    = n + 1;
    end
    return sum;
  endfunction

  function automatic int round_fx(longint unsigned v);
    return int'((v + (64'd1 << (DROP_BITS - 1))) >> DROP_BITS);
  endfunction

  task automatic build_atan_tab();
    longint unsigned quarter;
    quarter = atan_series(1, 1);
    for (int i = 0; i < LUT_ENTRIES; i++)
      atan_tab[i] = round_fx(atan_series(longint'(i), LUT_ENTRIES - 1));
    pi_fx      = round_fx(4 * quarter);
    half_pi_fx = round_fx(2 * quarter);
  endtask

  // expected angle for one vector: magnitudes, ratio index, octant fold
  function automatic logic signed [ANGLE_W-1:0] atan2_fold(vec_pair_t p);
    int   ax;
    int   ay;
    int   mn;
    int   mx;
    int   idx;
    int   t;
    int   a;
    oct_t code;
    ax = (p.x < 0) ? -int'(p.x) : int'(p.x);
    ay = (p.y < 0) ? -int'(p.y) : int'(p.y);
    if (ax == 0 && ay == 0) return '0;
    mn  = (ax <= ay) ? ax : ay;
    mx  = (ax <= ay) ? ay : ax;
    idx = ((LUT_ENTRIES - 1) * mn) / mx;
    if (idx > LUT_ENTRIES - 1) idx = LUT_ENTRIES - 1;
    t    = atan_tab[idx];
    code = oct_t'({p.x < 0, p.y < 0, ax <= ay});
    case (code)
      OCT_XP_YP_LO: a = t;
      OCT_XP_YP_HI: a = half_pi_fx - t;
      OCT_XP_YN_LO: a = -t;
      OCT_XP_YN_HI: a = t - half_pi_fx;
      OCT_XN_YP_LO: a = pi_fx - t;
      OCT_XN_YP_HI: a = half_pi_fx + t;
      OCT_XN_YN_LO: a = t - pi_fx;
      default:      a = -half_pi_fx - t;
    endcase
    return ANGLE_W'(a);
  endfunction

  function automatic int clamp_in(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int rand_in();
    return int'($signed(16'($urandom)));
  endfunction

  task automatic add_pair(int x, int y);
    vec_pair_t p;
    p.x = IN_W'(clamp_in(x));
    p.y = IN_W'(clamp_in(y));
    pair_q.push_back(p);
  endtask

  // random vector: full range in four of ten draws, the rest small values,
  // near-diagonal octant borders, axes/extremes and very lopsided ratios
  task automatic add_rand_pair();
    int kind;
    int m;
    int x;
    int y;
    int sel;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        x = rand_in();
        y = rand_in();
      end
      4, 5: begin
        x = int'($urandom_range(0, 64)) - 32;
        y = int'($urandom_range(0, 64)) - 32;
      end
      6, 7: begin
        // around |x| == |y|, where the octant bit flips
        m = $urandom_range(0, 32768);
        x = $urandom_range(0, 1) ? -m : m;
        y = m + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) y = -y;
      end
      8: begin
        sel = $urandom_range(0, 4);
        case (sel)
          0:       x = 0;
          1:       x = -32768;
          2:       x = 32767;
          3:       x = 1;
          default: x = -1;
        endcase
        y = rand_in();
        if ($urandom_range(0, 1)) begin
          m = x; x = y; y = m;
        end
      end
      default: begin
        // tiny against huge, table index near zero
        x = rand_in();
        y = int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) begin
          m = x; x = y; y = m;
        end
      end
    endcase
    add_pair(x, y);
  endtask

  // driver: present the next pending vector once the current one is taken
  always @(posedge clk) begin : feed_proc
    logic      give;
    vec_pair_t cur;
    vec_pair_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      give = !in_valid;
      if (in_valid && !in_stall) begin
        cur.x = x_val;
        cur.y = y_val;
        angle_due_q.push_back('{src: cur, angle: atan2_fold(cur)});
        pairs_sent++;
        give = 1'b1;
      end
      if (give) begin
        if (pair_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pair_q.pop_front();
          x_val    <= nxt.x;
          y_val    <= nxt.y;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: each output transfer must match the oldest owed angle
  always @(posedge clk) begin : check_proc
    angle_due_t due;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        angles_seen++;
        if (angle_due_q.size() == 0) begin
          $display("%0t: unexpected angle transfer, expected none actual %0d",
                   $time, angle);
          errors++;
        end else begin
          due = angle_due_q.pop_front();
          if (angle !== due.angle) begin
            $display("%0t: angle mismatch x=%0d y=%0d expected %0d actual %0d",
                     $time, due.src.x, due.src.y, due.angle, angle);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : stim_proc
    int ph;
    int k;
    build_atan_tab();

    // corners: origin, both axes in both directions, most negative values,
    // exact diagonals in all four quadrants, and one vector per octant
    add_pair(0, 0);
    add_pair(1, 0);
    add_pair(32767, 0);
    add_pair(-1, 0);
    add_pair(-32768, 0);
    add_pair(0, 1);
    add_pair(0, 32767);
    add_pair(0, -32768);
    add_pair(-32768, -32768);
    add_pair(32767, 32767);
    add_pair(-32768, 32767);
    add_pair(32767, -32768);
    add_pair(5, 5);
    add_pair(5, -5);
    add_pair(-5, 5);
    add_pair(-5, -5);
    add_pair(255, 254);
    add_pair(3, 7);
    add_pair(7, -3);
    add_pair(3, -7);
    add_pair(-7, 3);
    add_pair(-3, 7);
    add_pair(-7, -3);
    add_pair(-3, -7);
    add_pair(-32768, 1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // phases: free running, sender gaps, receiver stalls, both
    for (ph = 0; ph <= LAST_PHASE; ph++) begin
      @(negedge clk);
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 65; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      for (k = 0; k < RAND_PER_PHASE; k++)
        add_rand_pair();
      while (pair_q.size() != 0) @(negedge clk);
    end

    while (in_valid || angle_due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d vector pairs sent, %0d angles checked, %0d mismatches",
             pairs_sent, angles_seen, errors);
    $display("covered origin, axes, diagonals, -32768 inputs and all octants");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog_proc
    #2_000_000;
    $display("%0t: run timed out with %0d angles still owed",
             $time, angle_due_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
